/* rtl/tccr_pkg.sv */
// package for the terminal cell colour resolver
// holds payload and control types, codes, the xterm reset palette and the faint scaling
// no dependencies
package tccr_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PALETTE_ADDR_W = $clog2(PALETTE_ENTRIES);
   localparam int RGB_W = 24;
   localparam int KIND_W = 2;
   localparam int CSR_INDEX_W = 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   localparam logic OP_RESOLVE = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // colour spec kinds, the unused code falls back to default
   localparam logic [KIND_W-1:0] KIND_DEFAULT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INDEXED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_FG = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_BG = 1'd1;

   localparam logic [RGB_W-1:0] DEFAULT_FG_RESET = 24'hDCDCDC;
   localparam logic [RGB_W-1:0] DEFAULT_BG_RESET = 24'h1E1E1E;

   typedef logic [RGB_W-1:0] rgb_type;

   typedef struct packed {
      logic                      operation;
      logic [KIND_W-1:0]         fg_kind;
      logic [PALETTE_ADDR_W-1:0] fg_index;
      rgb_type                   fg_rgb;
      logic [KIND_W-1:0]         bg_kind;
      logic [PALETTE_ADDR_W-1:0] bg_index;
      rgb_type                   bg_rgb;
      logic                      inverse_flag;
      logic                      faint_flag;
      logic                      invisible_flag;
      logic [PALETTE_ADDR_W-1:0] entry_index;
      rgb_type                   entry_color;
   } req_type;

   typedef struct packed {
      rgb_type fg_color;
      rgb_type bg_color;
   } rsp_type;

   // item as stored in the queue, with its class decoded on entry
   typedef struct packed {
      logic    is_write;
      logic    fg_lookup;
      logic    bg_lookup;
      req_type item;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } front_to_back_type;

   typedef struct packed {
      rgb_type default_fg;
      rgb_type default_bg;
   } cfg_type;

   typedef rgb_type palette_table_type [PALETTE_ENTRIES];

   localparam rgb_type BASE_COLOURS [16] = '{
      24'h000000, 24'hCD3131, 24'h0DBC79, 24'hE5E510,
      24'h2472C8, 24'hBC3FBC, 24'h11A8CD, 24'hE5E5E5,
      24'h666666, 24'hF14C4C, 24'h23D18B, 24'hF5F543,
      24'h3B8EEA, 24'hD670D6, 24'h29B8DB, 24'hFFFFFF
   };

   localparam logic [7:0] CUBE_LEVELS [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};

   localparam int CUBE_BASE = 16;
   localparam int CUBE_SIZE = 216;
   localparam int GREY_BASE = 232;
   localparam int GREY_STEPS = 24;

   // evaluated at elaboration only
   function automatic palette_table_type build_xterm_palette();
      palette_table_type tbl;
      int g;
      for (int i = 0; i < 16; i++) begin
         tbl[i] = BASE_COLOURS[i];
      end
      for (int i = 0; i < CUBE_SIZE; i++) begin
         tbl[CUBE_BASE + i] = {CUBE_LEVELS[(i / 36) % 6], CUBE_LEVELS[(i / 6) % 6],
                               CUBE_LEVELS[i % 6]};
      end
      for (int i = 0; i < GREY_STEPS; i++) begin
         g = 8 + i * 10;
         tbl[GREY_BASE + i] = {3{8'(g)}};
      end
      return tbl;
   endfunction

   localparam palette_table_type XTERM_PALETTE = build_xterm_palette();

   // round(2v/3) as (2v + 1) / 3, divide by 3 through 683 / 2048, exact below 2047
   function automatic logic [7:0] two_thirds(logic [7:0] v);
      logic [9:0]  t;
      logic [19:0] p;
      t = {1'b0, v, 1'b0} + 10'd1;
      p = 20'(t) * 20'd683;
      return p[18:11];
   endfunction

   function automatic rgb_type darken(rgb_type c);
      return {two_thirds(c[23:16]), two_thirds(c[15:8]), two_thirds(c[7:0])};
   endfunction

endpackage

/* rtl/tccr_ram.sv */
// generic single write, dual read ram with registered read data
// no dependencies
module tccr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* rtl/tccr_front.sv */
// front end: accepts transactions, decodes their class, and queues them for the back end
// depends on tccr_pkg
module tccr_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  tccr_pkg::req_type          req_payload,
   output tccr_pkg::front_to_back_type to_back
);

   tccr_pkg::queue_entry_type          queue_ff [tccr_pkg::QUEUE_DEPTH];
   logic [tccr_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [tccr_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [tccr_pkg::QUEUE_CNT_W-1:0]  count_ff;
   logic [tccr_pkg::QUEUE_CNT_W-1:0]  count_in;
   tccr_pkg::queue_entry_type          entry_in;
   logic                               full;
   logic                               push;
   logic                               pop;

   assign full = (count_ff == tccr_pkg::QUEUE_CNT_W'(tccr_pkg::QUEUE_DEPTH));
   assign busy = reset | full;
   assign push = start & ~busy;
   // back end never stalls, head leaves as soon as it is there
   assign pop = (count_ff != '0);

   always_comb begin
      entry_in.item = req_payload;
      entry_in.is_write = (req_payload.operation == tccr_pkg::OP_WRITE);
      entry_in.fg_lookup = (req_payload.fg_kind == tccr_pkg::KIND_INDEXED);
      entry_in.bg_lookup = (req_payload.bg_kind == tccr_pkg::KIND_INDEXED);
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign to_back.valid = pop;
   assign to_back.entry = queue_ff[rd_ptr_ff];

endmodule

/* rtl/tccr_back.sv */
// back end: palette writes, palette lookup, flag handling and the result register
// depends on tccr_pkg and tccr_ram
module tccr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  tccr_pkg::front_to_back_type from_front,
   input  tccr_pkg::cfg_type           cfg,
   output logic                        rsp_strobe,
   output tccr_pkg::rsp_type           rsp_payload
);

   tccr_pkg::req_type                  item;
   logic                               do_write;
   logic                               do_resolve;
   logic [tccr_pkg::PALETTE_ENTRIES-1:0] written_ff;

   logic                               s1_valid_ff;
   tccr_pkg::req_type                  s1_item_ff;
   logic                               s1_fg_hit_ff;
   logic                               s1_bg_hit_ff;
   tccr_pkg::rgb_type                  fg_ram;
   tccr_pkg::rgb_type                  bg_ram;

   tccr_pkg::rgb_type                  fg_pal;
   tccr_pkg::rgb_type                  bg_pal;
   tccr_pkg::rgb_type                  fg_base;
   tccr_pkg::rgb_type                  bg_base;
   tccr_pkg::rgb_type                  fg_swap;
   tccr_pkg::rgb_type                  bg_swap;
   tccr_pkg::rgb_type                  fg_faint;
   tccr_pkg::rsp_type                  rsp_in;
   logic                               rsp_valid_ff;
   tccr_pkg::rsp_type                  rsp_ff;

   assign item = from_front.entry.item;
   assign do_write = from_front.valid & from_front.entry.is_write;
   assign do_resolve = from_front.valid & ~from_front.entry.is_write;

   tccr_ram #(
      .WIDTH(tccr_pkg::RGB_W),
      .DEPTH(tccr_pkg::PALETTE_ENTRIES)
   ) u_palette (
      .clock     (clock),
      .wr_en     (do_write),
      .wr_addr   (item.entry_index),
      .wr_data   (item.entry_color),
      .rd_addr_a (item.fg_index),
      .rd_data_a (fg_ram),
      .rd_addr_b (item.bg_index),
      .rd_data_b (bg_ram)
   );

   // entries never written since reset read as the xterm palette
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (do_write) begin
         written_ff[item.entry_index] <= 1'b1;
      end
   end

   // lookup stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= do_resolve;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= item;
      s1_fg_hit_ff <= written_ff[item.fg_index];
      s1_bg_hit_ff <= written_ff[item.bg_index];
   end

   // resolve stage
   assign fg_pal = s1_fg_hit_ff ? fg_ram : tccr_pkg::XTERM_PALETTE[s1_item_ff.fg_index];
   assign bg_pal = s1_bg_hit_ff ? bg_ram : tccr_pkg::XTERM_PALETTE[s1_item_ff.bg_index];

   always_comb begin
      unique case (s1_item_ff.fg_kind)
         tccr_pkg::KIND_INDEXED: fg_base = fg_pal;
         tccr_pkg::KIND_DIRECT: fg_base = s1_item_ff.fg_rgb;
         default: fg_base = cfg.default_fg;
      endcase
      unique case (s1_item_ff.bg_kind)
         tccr_pkg::KIND_INDEXED: bg_base = bg_pal;
         tccr_pkg::KIND_DIRECT: bg_base = s1_item_ff.bg_rgb;
         default: bg_base = cfg.default_bg;
      endcase
   end

   always_comb begin
      fg_swap = s1_item_ff.inverse_flag ? bg_base : fg_base;
      bg_swap = s1_item_ff.inverse_flag ? fg_base : bg_base;
      fg_faint = s1_item_ff.faint_flag ? tccr_pkg::darken(fg_swap) : fg_swap;
      rsp_in.fg_color = s1_item_ff.invisible_flag ? bg_swap : fg_faint;
      rsp_in.bg_color = bg_swap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/terminal_cell_colour_resolver.sv */
// top level of the terminal cell colour resolver
// depends on tccr_pkg, tccr_front and tccr_back
//
// usage
//   request channel: a transaction is taken at a rising edge with start high and busy low.
//     operation selects a palette write (entry_index, entry_color) or a cell resolve
//     (foreground and background specs plus the inverse, faint and invisible flags)
//   response channel: one transaction per resolve, shown for exactly one cycle with
//     rsp_strobe high; writes give no response. the receiver cannot stall
//   register channel: csr_valid / csr_ready with csr_index and csr_data, always ready;
//     index 0 is the default foreground, index 1 the default background
//   response path: a resolve taken at a rising edge goes through the queue, then
//     the palette read, then the resolve and then the result register
//   throughput: one transaction per cycle, the back end drains the two-entry queue
//     every cycle and its single palette write port takes one write per cycle
//   reset: synchronous, busy stays high while reset is high; the queue and pipeline
//     empty, default colours return to 0xDCDCDC / 0x1E1E1E and all 256 palette entries
//     read as the xterm layout again at once (per-entry written bits, no clearing pass)
module terminal_cell_colour_resolver (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               start,
   output logic                               busy,
   input  tccr_pkg::req_type                  req_payload,
   // response channel
   output logic                               rsp_strobe,
   output tccr_pkg::rsp_type                  rsp_payload,
   // register channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tccr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  tccr_pkg::rgb_type                  csr_data
);

   tccr_pkg::front_to_back_type to_back;
   tccr_pkg::cfg_type           cfg;
   tccr_pkg::rgb_type           default_fg_ff;
   tccr_pkg::rgb_type           default_bg_ff;
   logic                        csr_write;

   // registers are never back-pressured
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_fg_ff <= tccr_pkg::DEFAULT_FG_RESET;
         default_bg_ff <= tccr_pkg::DEFAULT_BG_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            tccr_pkg::CSR_DEFAULT_FG: default_fg_ff <= csr_data;
            tccr_pkg::CSR_DEFAULT_BG: default_bg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign cfg.default_fg = default_fg_ff;
   assign cfg.default_bg = default_bg_ff;

   // front end: accept, decode class, queue
   tccr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .to_back     (to_back)
   );

   // back end: palette store, lookup and flag handling
   tccr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .from_front  (to_back),
      .cfg         (cfg),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/tccr_checker.sv */
// port-level checker for the terminal cell colour resolver, bound to the top level
// depends on tccr_pkg
module tccr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input tccr_pkg::req_type                req_payload,
   input logic                             rsp_strobe,
   input tccr_pkg::rsp_type                rsp_payload
);

   logic       take_resolve;
   logic       quiet;
   logic [2:0] reset_hist_ff;

   assign take_resolve = start & ~busy & (req_payload.operation == tccr_pkg::OP_RESOLVE);

   // reset history, three bits with the newest sample in bit 0
   always_ff @(posedge clock) begin
      reset_hist_ff <= {reset_hist_ff[1:0], reset};
   end

   // no reset held anywhere in the history
   assign quiet = ~|reset_hist_ff;

   // every resolve gives exactly one response, writes give none
   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      quiet |-> (rsp_strobe == $past(take_resolve, 3)))
      else $error("response does not line up with an accepted resolve");

   // invisible cells come out with equal colours
   a_invisible: assert property (@(posedge clock) disable iff (reset)
      (quiet && $past(take_resolve, 3) && $past(req_payload.invisible_flag, 3))
      |-> (rsp_payload.fg_color == rsp_payload.bg_color))
      else $error("invisible cell has differing colours");

   // direct colours with no flags pass straight through
   a_direct: assert property (@(posedge clock) disable iff (reset)
      (quiet && $past(take_resolve, 3)
       && $past(req_payload.fg_kind, 3) == tccr_pkg::KIND_DIRECT
       && $past(req_payload.bg_kind, 3) == tccr_pkg::KIND_DIRECT
       && !$past(req_payload.inverse_flag, 3) && !$past(req_payload.faint_flag, 3)
       && !$past(req_payload.invisible_flag, 3))
      |-> (rsp_payload.fg_color == $past(req_payload.fg_rgb, 3)
           && rsp_payload.bg_color == $past(req_payload.bg_rgb, 3)))
      else $error("direct colours altered");

   // faint foreground never exceeds two thirds of full scale
   a_faint: assert property (@(posedge clock) disable iff (reset)
      (quiet && $past(take_resolve, 3) && $past(req_payload.faint_flag, 3)
       && !$past(req_payload.invisible_flag, 3))
      |-> (rsp_payload.fg_color[23:16] <= 8'd170 && rsp_payload.fg_color[15:8] <= 8'd170
           && rsp_payload.fg_color[7:0] <= 8'd170))
      else $error("faint foreground component out of range");

endmodule

bind terminal_cell_colour_resolver tccr_checker u_tccr_checker (.*);
